/* sv/dependency_cycle_check_core_assert.svh */
// Assertion macros used by the dependency cycle check RTL.
`ifndef DEPENDENCY_CYCLE_CHECK_CORE_ASSERT_SVH
`define DEPENDENCY_CYCLE_CHECK_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCC_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("dependency cycle check: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DCC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("dependency cycle check: next-cycle check failed");

`endif

/* sv/dcc_pkg.sv */
// Shared types and constants for the dependency cycle check block.
`timescale 1ns / 1ps

package dcc_pkg;

    localparam int TASK_W = 7;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Register indexes on the configuration port
    localparam logic REG_NODE_COUNT = 1'b0;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic idle;
        logic take;
        logic set_err;
        logic load_rd;
        logic load_wr;
        logic seed_start;
        logic seed_rd;
        logic seed_chk;
        logic pop_rd;
        logic head_rd;
        logic edge_rd;
        logic edge_from_head;
        logic deg_rd;
        logic deg_upd;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_eval;
        logic load_bad;
        logic seed_done;
        logic queue_empty;
        logic head_link_zero;
        logic next_link_zero;
        logic out_free;
    } status_t;

endpackage

/* sv/dcc_if.sv */
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface dcc_item_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [dcc_pkg::TASK_W-1:0]  prereq_task;
    logic [dcc_pkg::TASK_W-1:0]  dependent_task;

    modport source (output valid, output kind, output prereq_task,
                    output dependent_task, input ready);
    modport sink (input valid, input kind, input prereq_task,
                  input dependent_task, output ready);
endinterface

interface dcc_result_if;
    logic                        valid;
    logic                        ready;
    logic                        feasible;
    logic [dcc_pkg::TASK_W-1:0]  processed_count;
    logic                        load_error;

    modport source (output valid, output feasible, output processed_count,
                    output load_error, input ready);
    modport sink (input valid, input feasible, input processed_count,
                  input load_error, output ready);
endinterface

/* sv/dcc_ctrl.sv */
// Controller state machine sequencing edge loads and the topological sort.
`timescale 1ns / 1ps
`include "dependency_cycle_check_core_assert.svh"

module dcc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  dcc_pkg::status_t status,
    output dcc_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DECODE    = 4'd1;
    localparam logic [3:0] ST_LOAD_WR   = 4'd2;
    localparam logic [3:0] ST_SEED_RD   = 4'd3;
    localparam logic [3:0] ST_SEED_CHK  = 4'd4;
    localparam logic [3:0] ST_POP       = 4'd5;
    localparam logic [3:0] ST_POP_WAIT  = 4'd6;
    localparam logic [3:0] ST_HEAD_WAIT = 4'd7;
    localparam logic [3:0] ST_EDGE_WAIT = 4'd8;
    localparam logic [3:0] ST_DEG_WAIT  = 4'd9;
    localparam logic [3:0] ST_FINISH    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       sort_end;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode the next state and the datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.idle = 1'b1;
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_eval)
                begin
                    cmd.seed_start = 1'b1;
                    state_next     = ST_SEED_RD;
                end
                else if (status.load_bad)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.load_rd = 1'b1;
                    state_next  = ST_LOAD_WR;
                end
            end
            ST_LOAD_WR:
            begin
                cmd.load_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_SEED_RD:
            begin
                if (status.seed_done)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.seed_rd = 1'b1;
                    state_next  = ST_SEED_CHK;
                end
            end
            ST_SEED_CHK:
            begin
                cmd.seed_chk = 1'b1;
                state_next   = ST_SEED_RD;
            end
            ST_POP:
            begin
                if (status.queue_empty)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                cmd.head_rd = 1'b1;
                state_next  = ST_HEAD_WAIT;
            end
            ST_HEAD_WAIT:
            begin
                if (status.head_link_zero)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.edge_rd        = 1'b1;
                    cmd.edge_from_head = 1'b1;
                    state_next         = ST_EDGE_WAIT;
                end
            end
            ST_EDGE_WAIT:
            begin
                cmd.deg_rd = 1'b1;
                state_next = ST_DEG_WAIT;
            end
            ST_DEG_WAIT:
            begin
                cmd.deg_upd = 1'b1;
                if (status.next_link_zero)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = ST_EDGE_WAIT;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sort ends when the ready queue runs dry
    assign sort_end = (state_reg == ST_POP) && status.queue_empty;

    // A taken item is always decoded next
    `DCC_ASSERT_NEXT(a_take_decode, clk, rst_n, cmd.take, state_reg == ST_DECODE)
    // Never overwrite a result that has not been transferred
    `DCC_ASSERT_SAME(a_finish_free, clk, rst_n, cmd.finish, status.out_free)
    // An empty ready queue ends the sort
    `DCC_ASSERT_NEXT(a_empty_finish, clk, rst_n, sort_end, state_reg == ST_FINISH)

endmodule

/* sv/dcc_datapath.sv */
// Datapath: adjacency lists, in-degree store, ready queue and result register.
`timescale 1ns / 1ps

module dcc_datapath #(
    parameter int MAX_TASKS = 128,
    parameter int MAX_EDGES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    dcc_item_if.sink                    item,
    dcc_result_if.source                result,
    input  logic [dcc_pkg::TASK_W-1:0]  node_count,
    input  dcc_pkg::cmd_t               cmd,
    output dcc_pkg::status_t            status
);

    localparam int TW   = dcc_pkg::TASK_W;
    localparam int SC_W = TW + 1;
    localparam int QD   = (MAX_TASKS < 128) ? MAX_TASKS : 128;
    localparam int TA_W = $clog2(QD);
    localparam int QP_W = $clog2(QD + 1);
    localparam int LK_W = $clog2(MAX_EDGES + 1);
    localparam int EI_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DG_W = LK_W;
    localparam logic [TW-1:0]   TASK_LIM  = TW'((MAX_TASKS - 1 < 127) ? MAX_TASKS - 1 : 127);
    localparam logic [LK_W-1:0] EDGE_FULL = LK_W'(MAX_EDGES);

    // Captured input item
    logic            kind_reg;
    logic [TW-1:0]   src_reg;
    logic [TW-1:0]   dst_reg;

    // Graph control state
    logic [LK_W-1:0] edge_used_reg;
    logic            error_reg;
    logic [QD-1:0]   head_vld_reg;
    logic [QD-1:0]   deg_vld_reg;
    logic [QP_W-1:0] front_reg;
    logic [QP_W-1:0] rear_reg;
    logic [SC_W-1:0] scan_reg;

    // Memories and their registered read data
    logic [LK_W-1:0] head_mem [QD];
    logic [DG_W-1:0] deg_mem [QD];
    logic [TA_W-1:0] tgt_mem [MAX_EDGES];
    logic [LK_W-1:0] nxt_mem [MAX_EDGES];
    logic [TA_W-1:0] q_mem [QD];
    logic [LK_W-1:0] head_rd_reg;
    logic            hvld_rd_reg;
    logic [DG_W-1:0] deg_rd_reg;
    logic            dvld_rd_reg;
    logic [TA_W-1:0] tgt_rd_reg;
    logic [LK_W-1:0] nxt_rd_reg;
    logic [TA_W-1:0] q_rd_reg;

    // Result register
    logic            res_vld_reg;
    logic            feasible_reg;
    logic [TW-1:0]   count_reg;
    logic            lerr_reg;

    logic [TW-1:0]   task_n;
    logic [TA_W-1:0] src_idx;
    logic [TA_W-1:0] dst_idx;
    logic [TA_W-1:0] scan_idx;
    logic [TA_W-1:0] head_addr;
    logic [TA_W-1:0] deg_addr;
    logic [LK_W-1:0] head_eff;
    logic [DG_W-1:0] deg_eff;
    logic            deg_zero;
    logic [LK_W-1:0] link_sel;
    logic [LK_W-1:0] link_m1;
    logic [EI_W-1:0] edge_addr;
    logic            deg_wr;
    logic [TA_W-1:0] deg_wr_addr;
    logic [DG_W-1:0] deg_wr_data;
    logic            push_en;
    logic [TA_W-1:0] push_data;

    // Task count in use, limited by the store depth
    assign task_n = (node_count > TASK_LIM) ? TASK_LIM : node_count;

    assign src_idx  = src_reg[TA_W-1:0];
    assign dst_idx  = dst_reg[TA_W-1:0];
    assign scan_idx = scan_reg[TA_W-1:0];

    // Unwritten entries read as their cleared value
    assign head_eff = hvld_rd_reg ? head_rd_reg : '0;
    assign deg_eff  = dvld_rd_reg ? deg_rd_reg : '0;
    assign deg_zero = (deg_eff == '0);

    assign head_addr = cmd.head_rd ? q_rd_reg : src_idx;
    assign deg_addr  = cmd.seed_rd ? scan_idx : (cmd.deg_rd ? tgt_rd_reg : dst_idx);

    assign link_sel  = cmd.edge_from_head ? head_eff : nxt_rd_reg;
    assign link_m1   = link_sel - 1'b1;
    assign edge_addr = link_m1[EI_W-1:0];

    // In-degree write: raise on load, lower on sort
    assign deg_wr      = cmd.load_wr || (cmd.deg_upd && !deg_zero);
    assign deg_wr_addr = cmd.load_wr ? dst_idx : tgt_rd_reg;
    assign deg_wr_data = cmd.load_wr ? (deg_eff + 1'b1) : (deg_eff - 1'b1);

    // Ready-queue push from the seed scan or from a successor reaching zero
    assign push_en = (cmd.seed_chk && deg_zero) ||
                     (cmd.deg_upd && (deg_eff == DG_W'(1)) && (TW'(tgt_rd_reg) <= task_n));
    assign push_data = cmd.seed_chk ? scan_idx : tgt_rd_reg;

    // Status towards the controller
    always_comb
    begin
        status.is_eval        = kind_reg;
        status.load_bad       = (src_reg == '0) || (src_reg > task_n) ||
                                (dst_reg == '0) || (dst_reg > task_n) ||
                                (edge_used_reg >= EDGE_FULL);
        status.seed_done      = (scan_reg > SC_W'(task_n));
        status.queue_empty    = (front_reg == rear_reg);
        status.head_link_zero = (head_eff == '0);
        status.next_link_zero = (nxt_rd_reg == '0);
        status.out_free       = !res_vld_reg || result.ready;
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            kind_reg <= item.kind;
            src_reg  <= item.prereq_task;
            dst_reg  <= item.dependent_task;
        end
    end

    // Hold graph counters, flags and valid bits; drop them after a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_used_reg <= '0;
            error_reg     <= 1'b0;
            head_vld_reg  <= '0;
            deg_vld_reg   <= '0;
            front_reg     <= '0;
            rear_reg      <= '0;
            scan_reg      <= '0;
        end
        else if (cmd.finish)
        begin
            edge_used_reg <= '0;
            error_reg     <= 1'b0;
            head_vld_reg  <= '0;
            deg_vld_reg   <= '0;
            front_reg     <= '0;
            rear_reg      <= '0;
        end
        else
        begin
            if (cmd.set_err)
            begin
                error_reg <= 1'b1;
            end
            if (cmd.load_wr)
            begin
                edge_used_reg         <= edge_used_reg + 1'b1;
                head_vld_reg[src_idx] <= 1'b1;
            end
            if (deg_wr)
            begin
                deg_vld_reg[deg_wr_addr] <= 1'b1;
            end
            if (cmd.seed_start)
            begin
                front_reg <= '0;
                rear_reg  <= '0;
                scan_reg  <= SC_W'(1);
            end
            else
            begin
                if (cmd.seed_chk)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (cmd.pop_rd)
                begin
                    front_reg <= front_reg + 1'b1;
                end
                if (push_en)
                begin
                    rear_reg <= rear_reg + 1'b1;
                end
            end
        end
    end

    // List head store
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            head_mem[src_idx] <= edge_used_reg + 1'b1;
        end
        if (cmd.load_rd || cmd.head_rd)
        begin
            head_rd_reg <= head_mem[head_addr];
            hvld_rd_reg <= head_vld_reg[head_addr];
        end
    end

    // In-degree store
    always_ff @(posedge clk)
    begin
        if (deg_wr)
        begin
            deg_mem[deg_wr_addr] <= deg_wr_data;
        end
        if (cmd.load_rd || cmd.seed_rd || cmd.deg_rd)
        begin
            deg_rd_reg  <= deg_mem[deg_addr];
            dvld_rd_reg <= deg_vld_reg[deg_addr];
        end
    end

    // Edge target and next-link stores
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            tgt_mem[edge_used_reg[EI_W-1:0]] <= dst_idx;
            nxt_mem[edge_used_reg[EI_W-1:0]] <= head_eff;
        end
        if (cmd.edge_rd)
        begin
            tgt_rd_reg <= tgt_mem[edge_addr];
            nxt_rd_reg <= nxt_mem[edge_addr];
        end
    end

    // Ready queue
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            q_mem[rear_reg[TA_W-1:0]] <= push_data;
        end
        if (cmd.pop_rd)
        begin
            q_rd_reg <= q_mem[front_reg[TA_W-1:0]];
        end
    end

    // Result valid: set on finish, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    // Result payload; processed count equals the number of pops
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            feasible_reg <= (SC_W'(front_reg) == SC_W'(task_n));
            count_reg    <= TW'(front_reg);
            lerr_reg     <= error_reg;
        end
    end

    assign result.valid           = res_vld_reg;
    assign result.feasible        = feasible_reg;
    assign result.processed_count = count_reg;
    assign result.load_error      = lerr_reg;

endmodule

/* sv/dependency_cycle_check_core.sv */
// Top level of the dependency cycle check block.
// Edge items (kind 0) add one dependency each, or are dropped for a bad task
// number or a full edge store. An evaluate item (kind 1) runs Kahn's sort:
// it scans the N tasks for zero in-degree, then takes each task from the
// ready queue and walks its edges, and finally posts the result. The list
// head, in-degree, edge and queue memories have registered reads, which the
// controller steps through one access at a time. The result register
// lets the next item start while a result waits to be transferred; the
// graph is cleared at once when the result is posted, with no sweep.
`timescale 1ns / 1ps

module dependency_cycle_check_core #(
    parameter int MAX_TASKS = 128,
    parameter int MAX_EDGES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    dcc_item_if.sink                    item,
    dcc_result_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [dcc_pkg::DATA_W-1:0]  pwdata,
    output logic [dcc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    dcc_pkg::cmd_t               cmd;
    dcc_pkg::status_t            status;
    logic [dcc_pkg::TASK_W-1:0]  node_count_reg;
    logic                        reg_sel;

    // Register file: node count only
    assign pready  = 1'b1;
    assign reg_sel = (paddr[dcc_pkg::ADDR_W-1:2] == dcc_pkg::REG_NODE_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= dcc_pkg::TASK_W'(1);
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            node_count_reg <= pwdata[dcc_pkg::TASK_W-1:0];
        end
    end

    assign prdata = reg_sel ? dcc_pkg::DATA_W'(node_count_reg) : '0;

    // Input channel is ready only while the controller waits for an item
    assign item.ready = cmd.idle;

    dcc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .status     (status),
        .cmd        (cmd)
    );

    dcc_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .node_count (node_count_reg),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the dependency cycle check core (Kahn sort).
`timescale 1ns / 1ps

module testbench;

    localparam int TASK_W = dcc_pkg::TASK_W;
    localparam int ADDR_W = dcc_pkg::ADDR_W;
    localparam int DATA_W = dcc_pkg::DATA_W;

    localparam int TASK_SLOTS   = 128;
    localparam int EDGE_SLOTS   = 1024;
    localparam int RANDOM_ITEMS = 340;
    localparam int QUIET_CYCLES = 12;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef struct packed {
        logic             feasible;
        logic [TASK_W-1:0] processed_count;
        logic             load_error;
    } verdict_t;

    localparam verdict_t NIL = '0;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_op_t;

    // One step of the directed plan; for ROW_CFG the value sits in src
    typedef struct packed {
        row_op_t           op;
        logic              kind;
        logic [TASK_W-1:0] src;
        logic [TASK_W-1:0] dst;
        logic              fixed;
        verdict_t          want;
    } plan_row_t;

    localparam int PLAN_ROWS = 29;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // fresh from reset: one task, no edges
        '{ROW_ITEM, KIND_EVAL, 7'd0,   7'd0,   1'b1, '{1'b1, 7'd1,   1'b0}},
        // widest task range, two-task cycle across the extremes
        '{ROW_CFG,  KIND_EDGE, 7'd127, 7'd0,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd127, 7'd1,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd1,   7'd127, 1'b0, NIL},
        '{ROW_ITEM, KIND_EVAL, 7'd0,   7'd0,   1'b1, '{1'b0, 7'd125, 1'b0}},
        // task zero on either end is dropped
        '{ROW_ITEM, KIND_EDGE, 7'd0,   7'd5,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd5,   7'd0,   1'b0, NIL},
        '{ROW_ITEM, KIND_EVAL, 7'd0,   7'd0,   1'b1, '{1'b1, 7'd127, 1'b1}},
        // no tasks in use at all
        '{ROW_CFG,  KIND_EDGE, 7'd0,   7'd0,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd1,   7'd1,   1'b0, NIL},
        '{ROW_ITEM, KIND_EVAL, 7'd0,   7'd0,   1'b1, '{1'b1, 7'd0,   1'b1}},
        // self edge forms a cycle
        '{ROW_CFG,  KIND_EDGE, 7'd3,   7'd0,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd2,   7'd2,   1'b0, NIL},
        '{ROW_ITEM, KIND_EVAL, 7'd0,   7'd0,   1'b1, '{1'b0, 7'd2,   1'b0}},
        // duplicate edge in a chain, prerequisite above range
        '{ROW_CFG,  KIND_EDGE, 7'd4,   7'd0,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd1,   7'd2,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd1,   7'd2,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd2,   7'd3,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd3,   7'd4,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd5,   7'd1,   1'b0, NIL},
        '{ROW_ITEM, KIND_EVAL, 7'd0,   7'd0,   1'b0, NIL},
        // task range lowered after loading
        '{ROW_CFG,  KIND_EDGE, 7'd6,   7'd0,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd1,   7'd5,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd5,   7'd6,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd6,   7'd2,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd3,   7'd4,   1'b0, NIL},
        '{ROW_CFG,  KIND_EDGE, 7'd4,   7'd0,   1'b0, NIL},
        '{ROW_ITEM, KIND_EDGE, 7'd2,   7'd127, 1'b0, NIL},
        '{ROW_ITEM, KIND_EVAL, 7'd0,   7'd0,   1'b0, NIL}
    };

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dcc_item_if   item_bus ();
    dcc_result_if result_bus ();

    dependency_cycle_check_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow graph: adjacency lists, in-degrees and the drop flag
    logic [10:0]       head_link [TASK_SLOTS];
    logic [TASK_W-1:0] link_dst  [EDGE_SLOTS];
    logic [10:0]       link_next [EDGE_SLOTS];
    logic [10:0]       pend_deg  [TASK_SLOTS];
    int                edges_held;
    logic              drop_seen;
    logic [TASK_W-1:0] node_limit;

    verdict_t expected_verdicts [$];
    int       mismatch_count = 0;
    bit       steady = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int pick_wait();
        return steady ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic void clear_graph_model();
        for (int t = 0; t < TASK_SLOTS; t++)
        begin
            head_link[t] = '0;
            pend_deg[t]  = '0;
        end
        edges_held = 0;
        drop_seen  = 1'b0;
    endfunction

    // Link one dependency, or drop it for a bad task number or a full store
    function automatic void graph_add_edge(input logic [TASK_W-1:0] src,
                                           input logic [TASK_W-1:0] dst);
        if (src == 0 || src > node_limit || dst == 0 || dst > node_limit ||
            edges_held >= EDGE_SLOTS)
        begin
            drop_seen = 1'b1;
        end
        else
        begin
            link_dst[edges_held]  = dst;
            link_next[edges_held] = head_link[src];
            head_link[src]        = 11'(edges_held + 1);
            edges_held++;
            pend_deg[dst]++;
        end
    endfunction

    // Run Kahn's sort over the shadow graph, then clear it
    function automatic verdict_t kahn_outcome();
        logic [TASK_W-1:0] order [TASK_SLOTS];
        int                rd;
        int                wr;
        int                link;
        int                taken;
        logic [TASK_W-1:0] u;
        logic [TASK_W-1:0] v;
        verdict_t          r;
        rd    = 0;
        wr    = 0;
        taken = 0;
        for (int t = 1; t <= int'(node_limit); t++)
        begin
            if (pend_deg[t] == 0)
            begin
                order[wr] = TASK_W'(t);
                wr++;
            end
        end
        while (rd < wr)
        begin
            u = order[rd];
            rd++;
            taken++;
            link = int'(head_link[u]);
            while (link != 0)
            begin
                v = link_dst[link - 1];
                if (pend_deg[v] != 0)
                begin
                    pend_deg[v]--;
                    // successors above the task range lose in-degree only
                    if (pend_deg[v] == 0 && v >= 1 && v <= node_limit)
                    begin
                        order[wr] = v;
                        wr++;
                    end
                end
                link = int'(link_next[link - 1]);
            end
        end
        r.feasible        = (taken == int'(node_limit));
        r.processed_count = TASK_W'(taken);
        r.load_error      = drop_seen;
        clear_graph_model();
        return r;
    endfunction

    // Present one item after a random gap and hold it until the transfer
    task automatic offer_item(input logic kind, input logic [TASK_W-1:0] src,
                              input logic [TASK_W-1:0] dst, input logic fixed,
                              input verdict_t want);
        int       gap;
        verdict_t got;
        gap = pick_wait();
        if (gap != 0)
        begin
            @(negedge clk);
            item_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_bus.valid          <= 1'b1;
        item_bus.kind           <= kind;
        item_bus.prereq_task    <= src;
        item_bus.dependent_task <= dst;
        do @(posedge clk); while (!item_bus.ready);
        if (kind == KIND_EDGE)
        begin
            graph_add_edge(src, dst);
        end
        else
        begin
            got = kahn_outcome();
            expected_verdicts.push_back(fixed ? want : got);
        end
    endtask

    // Drop valid, drain every pending result, then let the block go idle
    task automatic settle();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Write the task count, then read it back
    task automatic cfg_write(input logic [TASK_W-1:0] value);
        logic [DATA_W-1:0] back;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(dcc_pkg::REG_NODE_COUNT));
        pwdata  <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        node_limit = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        back = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (back[TASK_W-1:0] !== value)
            note_mismatch($sformatf("node_count read %0d, wrote %0d",
                                    back[TASK_W-1:0], value));
    endtask

    task automatic check_verdict();
        verdict_t want;
        if (expected_verdicts.size() == 0)
        begin
            note_mismatch("result transfer with nothing expected");
            return;
        end
        want = expected_verdicts.pop_front();
        if (result_bus.feasible !== want.feasible)
            note_mismatch($sformatf("feasible %b, expected %b",
                                    result_bus.feasible, want.feasible));
        if (result_bus.processed_count !== want.processed_count)
            note_mismatch($sformatf("processed_count %0d, expected %0d",
                                    result_bus.processed_count, want.processed_count));
        if (result_bus.load_error !== want.load_error)
            note_mismatch($sformatf("load_error %b, expected %b",
                                    result_bus.load_error, want.load_error));
    endtask

    // Result side: stall a random number of cycles once a result is offered
    initial
    begin : result_sink
        int stall;
        result_bus.ready = 1'b0;
        forever
        begin
            stall = pick_wait();
            if (stall != 0)
            begin
                @(negedge clk);
                result_bus.ready <= 1'b0;
                do @(posedge clk); while (!result_bus.valid);
                repeat (stall - 1) @(posedge clk);
                @(negedge clk);
                result_bus.ready <= 1'b1;
            end
            else if (!result_bus.ready)
            begin
                @(negedge clk);
                result_bus.ready <= 1'b1;
            end
            do @(posedge clk); while (!(result_bus.valid && result_bus.ready));
            check_verdict();
        end
    end

    // Stimulus: directed plan, a full edge store, then random graphs
    initial
    begin : stimulus
        int                pick;
        int                edge_cnt;
        int                style;
        int                items_left;
        logic [TASK_W-1:0] src_t;
        logic [TASK_W-1:0] dst_t;
        logic [TASK_W-1:0] new_count;

        rst_n                   = 1'b0;
        item_bus.valid          = 1'b0;
        item_bus.kind           = KIND_EDGE;
        item_bus.prereq_task    = '0;
        item_bus.dependent_task = '0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        node_limit              = 7'd1;
        clear_graph_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (PLAN[r].op == ROW_CFG)
            begin
                settle();
                cfg_write(PLAN[r].src);
            end
            else
            begin
                offer_item(PLAN[r].kind, PLAN[r].src, PLAN[r].dst, PLAN[r].fixed,
                           PLAN[r].want);
            end
        end

        // Overfill the edge store with an acyclic graph
        steady = 1'b1;
        settle();
        cfg_write(7'd40);
        for (int i = 0; i < EDGE_SLOTS + 6; i++)
        begin
            src_t = 7'($urandom_range(1, 39));
            dst_t = 7'($urandom_range(int'(src_t) + 1, 40));
            offer_item(KIND_EDGE, src_t, dst_t, 1'b0, NIL);
        end
        offer_item(KIND_EVAL, 7'd0, 7'd0, 1'b0, NIL);

        // Random graphs, mostly well-formed, some cyclic, some noise
        items_left = RANDOM_ITEMS;
        while (items_left > 0)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    new_count = 7'd0;
                else if (pick == 1)
                    new_count = 7'd127;
                else if (pick == 2)
                    new_count = 7'd1;
                else if (pick <= 4)
                    new_count = 7'($urandom_range(2, 127));
                else
                    new_count = 7'($urandom_range(2, 12));
                settle();
                cfg_write(new_count);
            end
            edge_cnt = $urandom_range(0, 24);
            style    = $urandom_range(0, 9);
            for (int i = 0; i < edge_cnt; i++)
            begin
                if (node_limit == 0 || $urandom_range(0, 19) == 0 ||
                    (style == 9 && $urandom_range(0, 1) == 0))
                begin
                    src_t = 7'($urandom_range(0, 127));
                    dst_t = 7'($urandom_range(0, 127));
                end
                else if (style < 5 && node_limit >= 2)
                begin
                    src_t = 7'($urandom_range(1, int'(node_limit) - 1));
                    dst_t = 7'($urandom_range(int'(src_t) + 1, int'(node_limit)));
                end
                else
                begin
                    src_t = 7'($urandom_range(1, int'(node_limit)));
                    dst_t = 7'($urandom_range(1, int'(node_limit)));
                end
                offer_item(KIND_EDGE, src_t, dst_t, 1'b0, NIL);
            end
            // Now and then shrink the task range before evaluating
            if (node_limit > 1 && $urandom_range(0, 7) == 0)
            begin
                settle();
                cfg_write(7'($urandom_range(1, int'(node_limit) - 1)));
            end
            offer_item(KIND_EVAL, 7'($urandom), 7'($urandom), 1'b0, NIL);
            items_left -= edge_cnt + 1;
        end

        settle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #(20_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* dependency_cycle_check_core.f */
+incdir+sv
sv/dcc_pkg.sv
sv/dcc_if.sv
sv/dcc_ctrl.sv
sv/dcc_datapath.sv
sv/dependency_cycle_check_core.sv
verif/testbench.sv
